@@ hw/rtl/ftws_pkg.sv @@
// Package for the frame time window statistics block.
// Holds the word types, the fixed field widths and the controller and datapath signal groups.
package ftws_pkg;

   localparam int TIME_W   = 20;
   localparam int SERIAL_W = 32;
   localparam int COUNT_W  = 8;

   typedef struct packed {
      logic [SERIAL_W-1:0] frame_serial;
      logic [TIME_W-1:0]   present_time;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0]  min_time;
      logic [TIME_W-1:0]  mean_time;
      logic [TIME_W-1:0]  max_time;
      logic [TIME_W-1:0]  slow_mean_time;
      logic [COUNT_W-1:0] window_count;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic scan;
      logic idx_clear;
      logic slow_step;
      logic div_mean;
      logic div_slow;
      logic keep_mean;
      logic keep_slow;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic scan_last;
      logic slow_last;
      logic div_done;
   } status_type;

endpackage

@@ hw/rtl/frame_time_window_statistics.sv @@
// Top level of the frame time window statistics block.
// Depends on ftws_pkg, ftws_ctrl and ftws_dp.
//
// Each accepted word updates the held frame time if it carries a new serial and a nonzero time,
// pushes a nonzero held time into a ring of the last WINDOW_DEPTH samples and returns min,
// mean, max and the mean of the slowest one percent of the window. The ring scan reads one
// entry per cycle from its single RAM read port, and the shared divider yields one quotient
// bit per cycle for each of the two means.
module frame_time_window_statistics #(
   parameter int WINDOW_DEPTH = 240
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ftws_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ftws_pkg::rsp_type rsp_data
);
   import ftws_pkg::*;

   cmd_type    cmd;
   status_type status;

   ftws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ftws_dp #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );
endmodule

@@ hw/rtl/ftws_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module ftws_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 240
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

@@ hw/rtl/ftws_div.sv @@
// Restoring divider that produces one quotient bit per cycle.
// Depends on nothing.
module ftws_div #(
   parameter int DVD_W = 28,
   parameter int DVS_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);
   localparam int CW = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DVS_W:0]   trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = CW'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DVS_W-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

@@ hw/rtl/ftws_dp.sv @@
// Datapath: held sample state, sample ring, window scan, slowest-sample list and divider.
// Depends on ftws_pkg, ftws_ram and ftws_div.
module ftws_dp #(
   parameter int WINDOW_DEPTH = 240
) (
   input  logic                clock,
   input  logic                reset,
   input  ftws_pkg::req_type   req_data,
   input  ftws_pkg::cmd_type   cmd,
   output ftws_pkg::status_type status,
   output ftws_pkg::rsp_type   rsp_data
);
   import ftws_pkg::*;

   localparam int IDX_W  = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = TIME_W + CNT_W;
   localparam int TOP_N  = (WINDOW_DEPTH + 99) / 100;
   localparam int TOP_IW = (TOP_N > 1) ? $clog2(TOP_N) : 1;
   localparam int KX_W   = CNT_W + 7;
   localparam int KP_W   = KX_W + 11;

   logic [SERIAL_W-1:0] last_serial_ff;
   logic [TIME_W-1:0]   held_ff, held_in;
   logic [IDX_W-1:0]    slot_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [CNT_W-1:0]    idx_ff;
   logic [CNT_W-1:0]    k_ff;
   logic                rd_vld_ff;
   logic [TIME_W-1:0]   min_ff, max_ff, mean_ff, slow_ff;
   logic [SUM_W-1:0]    sum_ff, slow_sum_ff;
   logic [TIME_W-1:0]   top_ff [TOP_N];
   logic [TIME_W-1:0]   top_in [TOP_N];
   logic                new_serial, wr_en;
   logic [TIME_W-1:0]   rd_data;
   logic [KP_W-1:0]     k_prod;
   logic                div_start, div_done;
   logic [SUM_W-1:0]    div_dvd, div_quo;
   logic [CNT_W-1:0]    div_dvs;
   rsp_type             rsp_ff;

   assign new_serial = (req_data.frame_serial != '0) &&
                       (req_data.frame_serial != last_serial_ff);
   assign held_in    = (new_serial && req_data.present_time != '0) ?
                       req_data.present_time : held_ff;
   assign wr_en      = cmd.accept && (held_in != '0);
   assign k_prod     = (KX_W'(count_ff) + KX_W'(99)) * KP_W'(1311);

   ftws_ram #(.WIDTH(TIME_W), .DEPTH(WINDOW_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot_ff),
      .wr_data (held_in),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      for (int i = 0; i < TOP_N; i++) begin
         if (rd_data > top_ff[i]) begin
            if (i == 0) begin
               top_in[i] = rd_data;
            end else if (rd_data <= top_ff[(i > 0) ? i - 1 : 0]) begin
               top_in[i] = rd_data;
            end else begin
               top_in[i] = top_ff[(i > 0) ? i - 1 : 0];
            end
         end else begin
            top_in[i] = top_ff[i];
         end
      end
   end

   assign div_start = cmd.div_mean || cmd.div_slow;
   assign div_dvd   = cmd.div_slow ? slow_sum_ff : sum_ff;
   assign div_dvs   = cmd.div_slow ? k_ff : count_ff;

   ftws_div #(.DVD_W(SUM_W), .DVS_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         last_serial_ff <= '0;
         held_ff        <= '0;
         slot_ff        <= '0;
         count_ff       <= '0;
         rd_vld_ff      <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan;
         if (cmd.accept) begin
            if (new_serial) begin
               last_serial_ff <= req_data.frame_serial;
            end
            held_ff <= held_in;
            if (wr_en) begin
               slot_ff <= (slot_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
               if (count_ff < CNT_W'(WINDOW_DEPTH)) begin
                  count_ff <= count_ff + 1'b1;
               end
            end
         end
      end
      k_ff <= CNT_W'(k_prod >> 17);
      if (cmd.accept || cmd.idx_clear) begin
         idx_ff <= '0;
      end else if (cmd.scan || cmd.slow_step) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.accept) begin
         min_ff      <= '1;
         max_ff      <= '0;
         sum_ff      <= '0;
         slow_sum_ff <= '0;
         for (int i = 0; i < TOP_N; i++) begin
            top_ff[i] <= '0;
         end
      end else begin
         if (rd_vld_ff) begin
            if (rd_data < min_ff) begin
               min_ff <= rd_data;
            end
            if (rd_data > max_ff) begin
               max_ff <= rd_data;
            end
            sum_ff <= sum_ff + SUM_W'(rd_data);
            top_ff <= top_in;
         end
         if (cmd.slow_step) begin
            slow_sum_ff <= slow_sum_ff + SUM_W'(top_ff[idx_ff[TOP_IW-1:0]]);
         end
      end
      if (cmd.keep_mean) begin
         mean_ff <= div_quo[TIME_W-1:0];
      end
      if (cmd.keep_slow) begin
         slow_ff <= div_quo[TIME_W-1:0];
      end
      if (cmd.load_rsp) begin
         if (count_ff == '0) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.min_time       <= min_ff;
            rsp_ff.mean_time      <= mean_ff;
            rsp_ff.max_time       <= max_ff;
            rsp_ff.slow_mean_time <= slow_ff;
            rsp_ff.window_count   <= count_ff[COUNT_W-1:0];
         end
      end
   end

   assign status.empty     = (count_ff == '0);
   assign status.scan_last = (idx_ff == count_ff - 1'b1);
   assign status.slow_last = (idx_ff == k_ff - 1'b1);
   assign status.div_done  = div_done;
   assign rsp_data         = rsp_ff;
endmodule

@@ hw/rtl/ftws_ctrl.sv @@
// Controller state machine: accept, scan, slow sum, two divisions, result; an empty window skips to result.
// Depends on ftws_pkg.
module ftws_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ftws_pkg::status_type status,
   output ftws_pkg::cmd_type    cmd
);
   import ftws_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SCAN, S_DRAIN, S_SLOW, S_DIVM_GO, S_DIVM_WAIT,
      S_DIVS_GO, S_DIVS_WAIT, S_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd           = '0;
      cmd.accept    = (state_ff == S_IDLE) && req_valid;
      cmd.scan      = (state_ff == S_SCAN) && !status.empty;
      cmd.idx_clear = (state_ff == S_DRAIN);
      cmd.slow_step = (state_ff == S_SLOW);
      cmd.div_mean  = (state_ff == S_DIVM_GO);
      cmd.div_slow  = (state_ff == S_DIVS_GO);
      cmd.keep_mean = (state_ff == S_DIVM_WAIT) && status.div_done;
      cmd.keep_slow = (state_ff == S_DIVS_WAIT) && status.div_done;
      cmd.load_rsp  = (state_ff == S_FINISH) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.load_rsp || (rsp_valid_ff && !rsp_ready);
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (status.empty) begin
                  state_ff <= S_FINISH;
               end else if (status.scan_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: state_ff <= S_SLOW;
            S_SLOW: begin
               if (status.slow_last) begin
                  state_ff <= S_DIVM_GO;
               end
            end
            S_DIVM_GO: state_ff <= S_DIVM_WAIT;
            S_DIVM_WAIT: begin
               if (status.div_done) begin
                  state_ff <= S_DIVS_GO;
               end
            end
            S_DIVS_GO: state_ff <= S_DIVS_WAIT;
            S_DIVS_WAIT: begin
               if (status.div_done) begin
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff)
      else $error("Result word dropped before it was taken.");
   a_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> out_free)
      else $error("Result register loaded while a word still waits.");
   a_acc: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> state_ff == S_SCAN)
      else $error("Accepted word did not start a scan.");
endmodule
